/* hw/rtl/vcm_pkg.sv */
package vcm_pkg;

  // Line store geometry
  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned WidthW     = ColW + 1;

  // Field and register widths
  localparam int unsigned PixW       = 16;
  localparam int unsigned RowW       = 16;
  localparam int unsigned ThrW       = 25;
  localparam int unsigned DepthW     = 5;
  localparam int unsigned LineW      = 13;
  localparam int unsigned HeightW    = 16;
  localparam int unsigned ShiftW     = 4;
  localparam int unsigned LineStoreW = 2 * PixW;

  // Pixel depth limits, the minimum frame height and the fixed post-threshold shift
  localparam int unsigned MinDepth   = 8;
  localparam int unsigned MaxDepth   = 16;
  localparam int unsigned MinHeight  = 3;
  localparam int unsigned MaskShift  = 8;

  // Datapath widths of the mask arithmetic
  localparam int unsigned DiffW      = PixW + 1;
  localparam int unsigned ProdW      = 2 * DiffW;
  localparam int unsigned ScaledW    = ProdW - MaskShift;

  // Configuration port
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = ThrW;
  localparam logic [CfgIdxW-1:0] CfgLower  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgUpper  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDepth  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWidth  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHeight = 3'd4;

  // Queue between front and back
  localparam int unsigned MidDepth   = 4;
  localparam int unsigned MidPtrW    = $clog2(MidDepth);
  localparam int unsigned MidCntW    = $clog2(MidDepth + 1);

  // Result queue
  localparam int unsigned OutDepth   = 8;
  localparam int unsigned OutPtrW    = $clog2(OutDepth);
  localparam int unsigned OutCntW    = $clog2(OutDepth + 1);

  // Effective configuration after clamping
  typedef struct packed {
    logic signed [ThrW-1:0] lower;
    logic signed [ThrW-1:0] upper;
    logic [ShiftW-1:0]      shift;
    logic [PixW-1:0]        peak;
    logic [WidthW-1:0]      width;
    logic [HeightW-1:0]     height;
  } cfg_t;

  // Item handed from front to back
  typedef struct packed {
    logic [PixW-1:0] above;
    logic [PixW-1:0] centre;
    logic [PixW-1:0] below;
    logic            compute;
    logic            last_row;
  } mid_item_t;

  // Status of the middle queue
  typedef struct packed {
    logic               empty;
    logic [MidCntW-1:0] count;
  } mid_stat_t;

  // Result queue entry
  typedef struct packed {
    logic [PixW-1:0] mask;
    logic            last;
  } out_item_t;

endpackage

/* hw/rtl/vcm_ram.sv */
module vcm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/vcm_front.sv */
module vcm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [vcm_pkg::PixW-1:0]  pixel_value_i,
  input  vcm_pkg::cfg_t             cfg_i,
  input  vcm_pkg::mid_stat_t        mid_stat_i,
  output logic                      full_o,
  output logic                      mid_push_o,
  output vcm_pkg::mid_item_t        mid_item_o
);
  import vcm_pkg::*;

  logic                  accept;
  logic [PixW-1:0]       px;
  logic                  last_row;
  logic                  last_col;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;

  logic                  s1_valid_q;
  logic [ColW-1:0]       s1_addr_q;
  logic [PixW-1:0]       s1_px_q;
  logic                  s1_emit_q;
  logic                  s1_compute_q;
  logic                  s1_last_row_q;
  logic                  s1_fwd_q;
  logic [LineStoreW-1:0] fwd_data_q;

  logic [LineStoreW-1:0] rd_data;
  logic [LineStoreW-1:0] line;
  logic [LineStoreW-1:0] wr_data;
  logic [PixW-1:0]       older;
  logic [PixW-1:0]       newer;

  // Hold off while the middle queue cannot take the item in flight and a new one
  assign full_o = ((MidCntW+1)'(mid_stat_i.count) + (MidCntW+1)'(s1_valid_q))
                  >= (MidCntW+1)'(MidDepth);
  assign accept = push_i & ~full_o;
  assign px     = pixel_value_i & cfg_i.peak;

  // Classify the position of the item in the frame
  assign last_row = ((RowW+1)'(row_q) + (RowW+1)'(1)) >= (RowW+1)'(cfg_i.height);
  assign last_col = (WidthW'(col_q) + WidthW'(1)) >= cfg_i.width;

  // Advance the raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
    end
  end

  // Capture the item while its column is read from the line store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q     <= col_q;
      s1_px_q       <= px;
      s1_emit_q     <= (row_q != '0);
      s1_compute_q  <= (row_q > RowW'(1));
      s1_last_row_q <= last_row;
      s1_fwd_q      <= s1_valid_q && (s1_addr_q == col_q);
      fwd_data_q    <= wr_data;
    end
  end

  // Both rows of one column share an entry: older row high, newer row low
  vcm_ram #(
    .WIDTH (LineStoreW),
    .DEPTH (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  // Forward the entry written in the same cycle as its read
  assign line    = s1_fwd_q ? fwd_data_q : rd_data;
  assign older   = line[LineStoreW-1:PixW];
  assign newer   = line[PixW-1:0];
  assign wr_data = {newer, s1_px_q};

  // Hand the neighborhood to the back
  assign mid_push_o          = s1_valid_q & s1_emit_q;
  assign mid_item_o.above    = older;
  assign mid_item_o.centre   = newer;
  assign mid_item_o.below    = s1_px_q;
  assign mid_item_o.compute  = s1_compute_q;
  assign mid_item_o.last_row = s1_last_row_q;

endmodule

/* hw/rtl/vcm_queue.sv */
module vcm_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  vcm_pkg::mid_item_t   item_i,
  input  logic                 pop_i,
  output vcm_pkg::mid_item_t   item_o,
  output vcm_pkg::mid_stat_t   stat_o
);
  import vcm_pkg::*;

  mid_item_t          mem_q [MidDepth];
  logic [MidPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [MidPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [MidCntW-1:0] count_q, count_d;

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == MidPtrW'(MidDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == MidPtrW'(MidDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

/* hw/rtl/vcm_back.sv */
module vcm_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vcm_pkg::cfg_t            cfg_i,
  input  vcm_pkg::mid_stat_t       mid_stat_i,
  input  vcm_pkg::mid_item_t       mid_item_i,
  output logic                     mid_pop_o,
  input  logic                     pop_i,
  output logic                     empty_o,
  output logic [vcm_pkg::PixW-1:0] mask_value_o,
  output logic                     last_of_run_o
);
  import vcm_pkg::*;

  logic                      phase_q, phase_d;
  logic                      issue;
  logic                      credit_ok;
  logic [OutCntW:0]          inflight;
  logic                      slot_zero;
  logic                      slot_last;

  logic                      va_q, vb_q, vc_q, vd_q;
  logic                      zero_a_q, zero_b_q, zero_c_q, zero_d_q;
  logic                      last_a_q, last_b_q, last_c_q, last_d_q;
  logic signed [DiffW-1:0]   d1_q, d2_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [ProdW-1:0]   scaled_q;
  logic                      lt_q, gt_q;
  logic signed [ScaledW-1:0] v_q;
  logic signed [ScaledW-1:0] peak_ext;
  logic [PixW-1:0]           mask;

  out_item_t                 out_mem_q [OutDepth];
  logic [OutPtrW-1:0]        out_wr_q, out_wr_d;
  logic [OutPtrW-1:0]        out_rd_q, out_rd_d;
  logic [OutCntW-1:0]        out_cnt_q, out_cnt_d;
  logic                      out_pop;
  out_item_t                 out_head;

  // Issue only when the result queue has room for everything in flight
  assign inflight  = (OutCntW+1)'(va_q) + (OutCntW+1)'(vb_q)
                   + (OutCntW+1)'(vc_q) + (OutCntW+1)'(vd_q);
  assign credit_ok = ((OutCntW+1)'(out_cnt_q) + inflight) < (OutCntW+1)'(OutDepth);
  assign issue     = ~mid_stat_i.empty & credit_ok;

  // A last-row item issues twice: its delayed mask, then a zero for itself
  assign slot_zero = phase_q | ~mid_item_i.compute;
  assign slot_last = phase_q | ~mid_item_i.last_row;
  assign mid_pop_o = issue & (phase_q | ~mid_item_i.last_row);
  assign phase_d   = issue ? (~phase_q & mid_item_i.last_row) : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      va_q    <= issue;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vd_q    <= vc_q;
    end
  end

  // Pipeline: differences, product, depth scaling, threshold compares and mask shift
  always_ff @(posedge clk_i) begin
    zero_a_q <= slot_zero;
    last_a_q <= slot_last;
    d1_q     <= $signed({1'b0, mid_item_i.above}) - $signed({1'b0, mid_item_i.centre});
    d2_q     <= $signed({1'b0, mid_item_i.below}) - $signed({1'b0, mid_item_i.centre});

    zero_b_q <= zero_a_q;
    last_b_q <= last_a_q;
    prod_q   <= ProdW'(d1_q) * ProdW'(d2_q);

    zero_c_q <= zero_b_q;
    last_c_q <= last_b_q;
    scaled_q <= prod_q >>> cfg_i.shift;

    zero_d_q <= zero_c_q;
    last_d_q <= last_c_q;
    lt_q     <= scaled_q < ProdW'(cfg_i.lower);
    gt_q     <= scaled_q > ProdW'(cfg_i.upper);
    v_q      <= ScaledW'(scaled_q >>> MaskShift);
  end

  // Select the mask value and saturate
  assign peak_ext = $signed({(ScaledW-PixW)'(0), cfg_i.peak});

  always_comb begin
    if (zero_d_q || lt_q) begin
      mask = '0;
    end else if (gt_q) begin
      mask = cfg_i.peak;
    end else if (v_q < 0) begin
      mask = '0;
    end else if (v_q > peak_ext) begin
      mask = cfg_i.peak;
    end else begin
      mask = v_q[PixW-1:0];
    end
  end

  // Result queue
  assign out_pop = pop_i & ~empty_o;

  always_comb begin
    out_wr_d  = out_wr_q;
    out_rd_d  = out_rd_q;
    out_cnt_d = out_cnt_q;
    if (vd_q) begin
      out_wr_d = (out_wr_q == OutPtrW'(OutDepth - 1)) ? '0 : out_wr_q + 1'b1;
    end
    if (out_pop) begin
      out_rd_d = (out_rd_q == OutPtrW'(OutDepth - 1)) ? '0 : out_rd_q + 1'b1;
    end
    if (vd_q && !out_pop) begin
      out_cnt_d = out_cnt_q + 1'b1;
    end else if (!vd_q && out_pop) begin
      out_cnt_d = out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      out_wr_q  <= out_wr_d;
      out_rd_q  <= out_rd_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vd_q) begin
      out_mem_q[out_wr_q] <= '{mask: mask, last: last_d_q};
    end
  end

  assign out_head      = out_mem_q[out_rd_q];
  assign empty_o       = (out_cnt_q == '0);
  assign mask_value_o  = out_head.mask;
  assign last_of_run_o = out_head.last;

endmodule

/* hw/rtl/vertical_comb_mask.sv */
// Vertical combing mask over a raster pixel stream.
// Input queue port: present pixel_value_i with push_i; it is taken on a rising
// edge where push_i is high and full_o is low. One pixel per cycle is accepted
// while the internal queues have room.
// Result queue port: while empty_o is low the oldest result is on mask_value_o
// and last_of_run_o; pop_i takes it. A stalled receiver fills an 8-entry result
// queue and a 4-entry middle queue, after which full_o rises.
// Results lag one row: the pixel at (row r, column c) puts the mask of
// (r-1, c) on the result ports once it has passed the front capture stage,
// the middle queue, the back pipeline and the result queue. Pixels of the
// first row yield nothing, pixels of the last row yield two results each (the
// last a zero), so the back issues twice for each pixel of a last row.
// Throughput is one pixel per cycle otherwise, while results are popped, set by
// the single line store memory, which is read and written once per pixel.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 lower threshold, 1 upper threshold, 2 bit depth, 3 line width,
// 4 frame height); write only while the block is idle.
// Reset clears the counters and queues and loads the default configuration;
// the line store is not cleared and is filled by the first rows of a frame.
module vertical_comb_mask (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [vcm_pkg::PixW-1:0]     pixel_value_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [vcm_pkg::PixW-1:0]     mask_value_o,
  output logic                         last_of_run_o,
  input  logic                         cfg_we_i,
  input  logic [vcm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vcm_pkg::CfgDataW-1:0] cfg_data_i
);
  import vcm_pkg::*;

  localparam logic signed [ThrW-1:0] LowerReset  = 25'sd30;
  localparam logic signed [ThrW-1:0] UpperReset  = 25'sd30;
  localparam logic [DepthW-1:0]      DepthReset  = 5'd8;
  localparam logic [LineW-1:0]       WidthReset  = 13'd1920;
  localparam logic [HeightW-1:0]     HeightReset = 16'd1080;

  logic signed [ThrW-1:0] lower_q;
  logic signed [ThrW-1:0] upper_q;
  logic [DepthW-1:0]      depth_q;
  logic [LineW-1:0]       line_width_q;
  logic [HeightW-1:0]     height_q;
  cfg_t                   cfg;

  logic                   mid_push;
  logic                   mid_pop;
  mid_item_t              mid_in;
  mid_item_t              mid_out;
  mid_stat_t              mid_stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q      <= LowerReset;
      upper_q      <= UpperReset;
      depth_q      <= DepthReset;
      line_width_q <= WidthReset;
      height_q     <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLower:  lower_q      <= cfg_data_i;
        CfgUpper:  upper_q      <= cfg_data_i;
        CfgDepth:  depth_q      <= cfg_data_i[DepthW-1:0];
        CfgWidth:  line_width_q <= cfg_data_i[LineW-1:0];
        CfgHeight: height_q     <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configuration to its working range
  always_comb begin
    cfg.lower = lower_q;
    cfg.upper = upper_q;
    if (32'(depth_q) < MinDepth) begin
      cfg.shift = '0;
    end else if (32'(depth_q) > MaxDepth) begin
      cfg.shift = ShiftW'(MaxDepth - MinDepth);
    end else begin
      cfg.shift = ShiftW'(32'(depth_q) - MinDepth);
    end
    cfg.peak = {PixW{1'b1}} >> (ShiftW'(MaxDepth - MinDepth) - cfg.shift);
    if (line_width_q == '0) begin
      cfg.width = WidthW'(1);
    end else if (32'(line_width_q) > MaxWidth) begin
      cfg.width = WidthW'(MaxWidth);
    end else begin
      cfg.width = WidthW'(line_width_q);
    end
    if (32'(height_q) < MinHeight) begin
      cfg.height = HeightW'(MinHeight);
    end else begin
      cfg.height = height_q;
    end
  end

  vcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .pixel_value_i (pixel_value_i),
    .cfg_i         (cfg),
    .mid_stat_i    (mid_stat),
    .full_o        (full_o),
    .mid_push_o    (mid_push),
    .mid_item_o    (mid_in)
  );

  vcm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .item_i (mid_in),
    .pop_i  (mid_pop),
    .item_o (mid_out),
    .stat_o (mid_stat)
  );

  vcm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .mid_stat_i    (mid_stat),
    .mid_item_i    (mid_out),
    .mid_pop_o     (mid_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .mask_value_o  (mask_value_o),
    .last_of_run_o (last_of_run_o)
  );

  // The front never pushes into a full middle queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> (mid_stat.count != MidCntW'(MidDepth)))
    else $error("middle queue overflow");

  // The back only pops a queue that holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_stat.empty)
    else $error("middle queue underflow");

  // A full queue count keeps the front stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_stat.count == MidCntW'(MidDepth)) |-> full_o)
    else $error("front open while middle queue full");

endmodule

/* tb/sv/vertical_comb_mask_tb.sv */
`timescale 1ns / 1ps

module vertical_comb_mask_tb;
  import vcm_pkg::*;

  localparam int unsigned NumRows     = 31;
  localparam int unsigned RandItems   = 1700;
  localparam int unsigned DrainCycles = 32;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  // One line of the directed plan: a register write or a pixel
  typedef struct packed {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                typed;
    logic [PixW-1:0]     mask;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                push_i        = 1'b0;
  logic [PixW-1:0]     pixel_value_i = '0;
  logic                pop_i         = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                full_o;
  logic                empty_o;
  logic [PixW-1:0]     mask_value_o;
  logic                last_of_run_o;

  // Mirror of the block's registers, line stores and raster position
  logic signed [ThrW-1:0] thr_lo     = 25'sd30;
  logic signed [ThrW-1:0] thr_hi     = 25'sd30;
  logic [DepthW-1:0]      depth_cfg  = 5'd8;
  logic [LineW-1:0]       width_cfg  = 13'd1920;
  logic [HeightW-1:0]     height_cfg = 16'd1080;
  logic [PixW-1:0]        prev2_row [MaxWidth];
  logic [PixW-1:0]        prev_row  [MaxWidth];
  int unsigned            col_pos    = 0;
  int unsigned            row_pos    = 0;

  out_item_t   mask_due_q [$];
  int unsigned err_cnt    = 0;
  bit          push_held  = 1'b0;
  bit          cfg_open   = 1'b0;
  int unsigned pop_hold   = 0;
  bit          pop_steady = 1'b0;
  stim_row_t   plan [NumRows];

  vertical_comb_mask uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .pixel_value_i (pixel_value_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .mask_value_o  (mask_value_o),
    .last_of_run_o (last_of_run_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_cnt++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned depth_eff();
    if (depth_cfg < MinDepth) return MinDepth;
    if (depth_cfg > MaxDepth) return MaxDepth;
    return depth_cfg;
  endfunction

  function automatic int unsigned width_eff(input logic [LineW-1:0] w);
    if (w == 0) return 1;
    if (w > MaxWidth) return MaxWidth;
    return w;
  endfunction

  // Scaled product of the two vertical differences, thresholded
  function automatic logic [PixW-1:0] comb_mask(input logic [PixW-1:0] above,
                                                input logic [PixW-1:0] centre,
                                                input logic [PixW-1:0] below,
                                                input int unsigned depth,
                                                input logic [PixW-1:0] peak);
    longint prod;
    longint scaled;
    longint v;
    prod   = (longint'(above) - longint'(centre)) * (longint'(below) - longint'(centre));
    scaled = prod >>> (depth - MinDepth);
    if (scaled < longint'(thr_lo)) return '0;
    if (scaled > longint'(thr_hi)) return peak;
    v = scaled >>> MaskShift;
    if (v < 0) return '0;
    if (v > longint'(peak)) return peak;
    return v[PixW-1:0];
  endfunction

  // Advance the mirror by one pixel and queue the masks it releases
  task automatic predict_comb(input logic [PixW-1:0] pix, input logic typed,
                              input logic [PixW-1:0] typed_mask);
    int unsigned     depth;
    int unsigned     peak_i;
    int unsigned     wid;
    int unsigned     hgt;
    logic [ColW-1:0] c;
    logic [PixW-1:0] peak;
    logic [PixW-1:0] px;
    logic [PixW-1:0] m;
    bit              last_row;
    bit              last_col;
    depth  = depth_eff();
    peak_i = (32'd1 << depth) - 1;
    peak   = peak_i[PixW-1:0];
    wid    = width_eff(width_cfg);
    hgt    = height_cfg;
    if (hgt < MinHeight) hgt = MinHeight;
    px       = pix & peak;
    c        = col_pos[ColW-1:0];
    last_row = (row_pos >= hgt - 1);
    last_col = (col_pos + 1 >= wid);
    if (row_pos >= 1) begin
      m = '0;
      if (row_pos >= 2) m = comb_mask(prev2_row[c], prev_row[c], px, depth, peak);
      if (typed) m = typed_mask;
      mask_due_q.push_back('{mask: m, last: !last_row});
      // the last row also yields its own zero
      if (last_row) mask_due_q.push_back('{mask: '0, last: 1'b1});
    end
    prev2_row[c] = prev_row[c];
    prev_row[c]  = px;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // Drop push and wait until the block has gone quiet
  task automatic settle();
    if (push_held) begin
      push_i    <= 1'b0;
      push_held  = 1'b0;
    end
    while (mask_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    if (!cfg_open) settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CfgLower:  thr_lo     = val;
      CfgUpper:  thr_hi     = val;
      CfgDepth:  depth_cfg  = val[DepthW-1:0];
      CfgWidth:  width_cfg  = val[LineW-1:0];
      CfgHeight: height_cfg = val[HeightW-1:0];
      default: ;
    endcase
    cfg_open = 1'b1;
  endtask

  task automatic cfg_close();
    if (cfg_open) begin
      cfg_we_i <= 1'b0;
      cfg_open  = 1'b0;
    end
  endtask

  // Offer one pixel, hold it until taken, then idle for a random gap, which may be none
  task automatic send_pixel(input logic [PixW-1:0] pix, input logic typed,
                            input logic [PixW-1:0] typed_mask, input bit steady);
    int unsigned gap;
    cfg_close();
    push_i        <= 1'b1;
    pixel_value_i <= pix;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    predict_comb(pix, typed, typed_mask);
    gap = steady ? 0 : gap_len();
    if (gap == 0) begin
      push_held = 1'b1;
    end else begin
      push_i    <= 1'b0;
      push_held  = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random values, extremes and values close to a per-burst base
  function automatic logic [PixW-1:0] pick_pixel(input logic [PixW-1:0] base);
    logic [31:0] rnd;
    int unsigned peak_i;
    peak_i = (32'd1 << depth_eff()) - 1;
    rnd    = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rnd[PixW-1:0];
      4:          return '0;
      5:          return '1;
      6:          return peak_i[PixW-1:0];
      default:    return base + {11'd0, rnd[4:0]};
    endcase
  endfunction

  // Receiver: pop with random stalls, sometimes without any
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 399) == 0) pop_steady = !pop_steady;
      if (pop_i && !empty_o && !pop_steady) pop_hold = gap_len();
      if (pop_hold != 0) begin
        pop_i <= 1'b0;
        pop_hold--;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // Compare each popped result with the oldest predicted mask
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (mask_due_q.size() == 0) begin
        report_mismatch($sformatf("result %0h with nothing expected", mask_value_o));
      end else begin
        want = mask_due_q.pop_front();
        if (mask_value_o !== want.mask)
          report_mismatch($sformatf("mask_value %0h, want %0h", mask_value_o, want.mask));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run_o, want.last));
      end
    end
  end

  initial begin : stimulus
    int unsigned     px_sent;
    int unsigned     count;
    int unsigned     k;
    int              lo_i;
    int              hi_i;
    logic [31:0]     rnd;
    logic [PixW-1:0] base;
    bit              steady;

    // Directed frames; masks typed in where they are obvious
    plan = '{
      // two pixels under the reset geometry, then shrink the row to three
      '{ROW_PIX, '0,        25'd255,       1'b0, 16'd0},
      '{ROW_PIX, '0,        25'd0,         1'b0, 16'd0},
      '{ROW_CFG, CfgWidth,  25'd3,         1'b0, 16'd0},
      '{ROW_CFG, CfgHeight, 25'd2,         1'b0, 16'd0},
      '{ROW_CFG, CfgDepth,  25'd0,         1'b0, 16'd0},
      '{ROW_CFG, CfgLower,  25'h1000000,   1'b0, 16'd0},
      '{ROW_CFG, CfgUpper,  25'h0FFFFFF,   1'b0, 16'd0},
      '{ROW_PIX, '0,        25'd255,       1'b0, 16'd0},
      // first row comes out as zeros; bits above the depth are ignored
      '{ROW_PIX, '0,        25'h000FF00,   1'b1, 16'd0},
      '{ROW_PIX, '0,        25'd255,       1'b1, 16'd0},
      '{ROW_PIX, '0,        25'd128,       1'b1, 16'd0},
      '{ROW_PIX, '0,        25'd255,       1'b1, 16'd254},
      '{ROW_PIX, '0,        25'h0000100,   1'b1, 16'd254},
      '{ROW_PIX, '0,        25'd0,         1'b1, 16'd0},
      // full depth: over the upper threshold gives the peak
      '{ROW_CFG, CfgDepth,  25'd31,        1'b0, 16'd0},
      '{ROW_CFG, CfgLower,  25'd0,         1'b0, 16'd0},
      '{ROW_CFG, CfgUpper,  25'd100,       1'b0, 16'd0},
      '{ROW_PIX, '0,        25'h000FFFF,   1'b0, 16'd0},
      '{ROW_PIX, '0,        25'd0,         1'b0, 16'd0},
      '{ROW_PIX, '0,        25'd1000,      1'b0, 16'd0},
      '{ROW_PIX, '0,        25'd0,         1'b1, 16'd0},
      '{ROW_PIX, '0,        25'h000FFFF,   1'b1, 16'd0},
      '{ROW_PIX, '0,        25'd500,       1'b1, 16'd0},
      '{ROW_PIX, '0,        25'h000FFFF,   1'b1, 16'hFFFF},
      '{ROW_PIX, '0,        25'd0,         1'b1, 16'hFFFF},
      '{ROW_PIX, '0,        25'd0,         1'b1, 16'd0},
      // zero width acts as a single column
      '{ROW_CFG, CfgWidth,  25'd0,         1'b0, 16'd0},
      '{ROW_CFG, CfgHeight, 25'd3,         1'b0, 16'd0},
      '{ROW_PIX, '0,        25'd7,         1'b0, 16'd0},
      '{ROW_PIX, '0,        25'd7,         1'b1, 16'd0},
      '{ROW_PIX, '0,        25'd7,         1'b1, 16'd0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) cfg_write(plan[i].idx, plan[i].data);
      else send_pixel(plan[i].data[PixW-1:0], plan[i].typed, plan[i].mask, 1'b0);
    end

    // Open the random part with the widest row, tallest frame, swapped extremes
    cfg_write(CfgLower,  25'h0FFFFFF);
    cfg_write(CfgUpper,  25'h1000000);
    cfg_write(CfgWidth,  25'd8191);
    cfg_write(CfgHeight, 25'd65535);

    px_sent = 0;
    while (px_sent < RandItems) begin
      // Keep long rows short-lived so they get cut by a later width write
      count  = (width_eff(width_cfg) > 64) ? $urandom_range(1, 24) : $urandom_range(8, 120);
      steady = ($urandom_range(0, 4) == 0);
      rnd    = $urandom;
      base   = rnd[PixW-1:0];
      repeat (count) begin
        send_pixel(pick_pixel(base), 1'b0, '0, steady);
        px_sent++;
      end

      // Retune between bursts, possibly in the middle of a frame
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: begin
            lo_i = -16777216;
            hi_i = 16777215;
          end
          1: begin
            lo_i = 16777215;
            hi_i = -16777216;
          end
          2: begin
            lo_i = int'($urandom_range(0, 33554431)) - 16777216;
            hi_i = int'($urandom_range(0, 33554431)) - 16777216;
          end
          default: begin
            k    = $urandom_range(4, 20);
            lo_i = int'($urandom_range(0, 2 << k)) - (1 << k);
            hi_i = lo_i + int'($urandom_range(0, 2 << k));
          end
        endcase
        cfg_write(CfgLower, lo_i[CfgDataW-1:0]);
        cfg_write(CfgUpper, hi_i[CfgDataW-1:0]);
      end
      if ($urandom_range(0, 3) != 0) begin
        rnd = ($urandom_range(0, 9) < 7) ? $urandom_range(8, 16) : $urandom_range(0, 31);
        cfg_write(CfgDepth, rnd[CfgDataW-1:0]);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0:       rnd = $urandom_range(0, 1) ? 32'd4096 : 32'd8191;
          1:       rnd = $urandom_range(65, 8191);
          2, 3, 4: rnd = $urandom_range(0, 40);
          default: rnd = $urandom_range(1, 8);
        endcase
        // mid-frame the row may only shrink, so no line store entry is read unwritten
        if ((col_pos != 0 || row_pos != 0) &&
            width_eff(rnd[LineW-1:0]) > width_eff(width_cfg))
          rnd = $urandom_range(0, width_eff(width_cfg));
        cfg_write(CfgWidth, rnd[CfgDataW-1:0]);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 11))
          0:       rnd = 32'd65535;
          1:       rnd = $urandom_range(0, 65535);
          default: rnd = $urandom_range(0, 8);
        endcase
        cfg_write(CfgHeight, rnd[CfgDataW-1:0]);
      end
    end

    cfg_close();
    settle();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #24_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/vcm_pkg.sv
hw/rtl/vcm_ram.sv
hw/rtl/vcm_front.sv
hw/rtl/vcm_queue.sv
hw/rtl/vcm_back.sv
hw/rtl/vertical_comb_mask.sv
tb/sv/vertical_comb_mask_tb.sv
